>>> hdl/scar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_pkg
// Shared types, register codes and delay line tables for the stereo reverb.
// ----------------------------------------------------------------------------
package scar_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 18;
  localparam int DAMP_W     = 25;
  localparam int MIX_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 25;
  localparam int POS_W      = 12;
  localparam int MULB_W     = 26;
  localparam int PROD_W     = SAMPLE_W + MULB_W;

  // Each lane keeps its own six lines; the lines of one bank fit in half the store.
  localparam int DELAY_STORE_DEPTH = 16384;
  localparam int LANE_DEPTH        = DELAY_STORE_DEPTH / 2;
  localparam int LANE_AW           = $clog2(LANE_DEPTH);
  localparam int LINES             = 6;

  // Highpass coefficient: (22500 << 32) / SAMPLE_RATE^2 at 44.1 kHz.
  localparam logic [MULB_W-1:0] HP_COEF = MULB_W'(49689);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [LANE_AW-1:0]         laddr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMB_A    = 4'd0,
    REG_COMB_B    = 4'd1,
    REG_COMB_C    = 4'd2,
    REG_COMB_D    = 4'd3,
    REG_ALLPASS_A = 4'd4,
    REG_ALLPASS_B = 4'd5,
    REG_DAMPING   = 4'd6,
    REG_MIX       = 4'd7
  } reg_idx_e;

  typedef struct packed {
    gain_t [3:0]       comb;
    gain_t             ap_a;
    gain_t             ap_b;
    logic [DAMP_W-1:0] damp;
    logic [MIX_W-1:0]  mix;
  } coef_t;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctrl_t;

  typedef struct packed {
    logic    done;
    sample_t result;
  } lane_stat_t;

  localparam gain_t RST_COMB_A    = 18'sd60864;
  localparam gain_t RST_COMB_B    = -18'sd59753;
  localparam gain_t RST_COMB_C    = 18'sd59161;
  localparam gain_t RST_COMB_D    = -18'sd58780;
  localparam gain_t RST_AP_A      = 18'sd64725;
  localparam gain_t RST_AP_B      = -18'sd65259;
  localparam logic [DAMP_W-1:0] RST_DAMP = 25'd11124314;

  // Line lengths in samples, four combs then two allpasses, per bank.
  localparam pos_t LINE_LEN [2][LINES] = '{
    '{12'd1309, 12'd1635, 12'd1811, 12'd1926, 12'd220, 12'd74},
    '{12'd934,  12'd1819, 12'd624,  12'd690,  12'd141, 12'd59}
  };

  // Start of each line inside its lane's store.
  localparam laddr_t LINE_BASE [2][LINES] = '{
    '{13'd0, 13'd1309, 13'd2944, 13'd4755, 13'd6681, 13'd6901},
    '{13'd0, 13'd934,  13'd2753, 13'd3377, 13'd4067, 13'd4208}
  };

endpackage

>>> hdl/scar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_if
// Handshake channels: input frame, output frame, register write.
// ----------------------------------------------------------------------------
interface scar_in_if;
  logic             valid;
  logic             ready;
  scar_pkg::sample_t left_in;
  scar_pkg::sample_t right_in;
  modport source(output valid, output left_in, output right_in, input ready);
  modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface scar_out_if;
  logic             valid;
  logic             ready;
  scar_pkg::sample_t left_out;
  scar_pkg::sample_t right_out;
  modport source(output valid, output left_out, output right_out, input ready);
  modport sink(input valid, input left_out, input right_out, output ready);
endinterface

interface scar_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [scar_pkg::CFG_IDX_W-1:0]      index;
  logic [scar_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> hdl/scar_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_lane
// One channel: highpass, four damped combs, two allpasses, wet scaling.
// ----------------------------------------------------------------------------
module scar_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bank_i,
  input  scar_pkg::coef_t      coef_i,
  input  scar_pkg::sample_t    sample_i,
  input  scar_pkg::lane_ctrl_t ctrl_i,
  output scar_pkg::lane_stat_t stat_o
);
  import scar_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CF_MUL, ST_CF_ADD, ST_X,
    ST_C_RD, ST_C_MUL, ST_C_SUB, ST_C_MUL2, ST_C_UPD,
    ST_A_RD, ST_A_MUL1, ST_A_Z1, ST_A_MUL2, ST_A_MUL3, ST_A_Z2, ST_A_MUL4,
    ST_A_OUT, ST_MIX_MUL, ST_MIX_OUT, ST_DONE
  } state_e;

  state_e state_q;
  logic [1:0] idx_q;
  pos_t  [LINES-1:0] pos_q;
  logic  [LINES-1:0] full_q;
  sample_t [3:0] damp_q;
  sample_t v_q, cf_q, x_q, t_q, sum_q, y1_q, y2_q, z_q, res_q;
  logic ok_q;
  logic signed [PROD_W-1:0] prod_q;

  sample_t mem_q [LANE_DEPTH];
  sample_t rdata_q;

  logic mem_re, mem_we;
  logic [2:0] rline, wline;
  sample_t mem_wdata;
  sample_t mul_a;
  logic signed [MULB_W-1:0] mul_b;
  sample_t rdm, nd, hp_in, zn;
  laddr_t raddr, waddr;

  assign rdm   = ok_q ? rdata_q : '0;
  assign hp_in = v_q - (cf_q >>> 8);
  assign nd    = damp_q[idx_q] + sample_t'(prod_q[55:24]);
  assign raddr = LINE_BASE[bank_i][rline] + LANE_AW'(pos_q[rline]);
  assign waddr = LINE_BASE[bank_i][wline] + LANE_AW'(pos_q[wline]);
  assign zn    = sample_t'(prod_q[47:16]);

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rline     = {1'b0, idx_q};
    wline     = {1'b0, idx_q};
    mem_wdata = nd;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_CF_MUL: begin
        mul_a = hp_in;
        mul_b = HP_COEF;
      end
      ST_C_RD: mem_re = 1'b1;
      ST_C_MUL: begin
        mul_a = rdm;
        mul_b = MULB_W'(coef_i.comb[idx_q]);
      end
      ST_C_MUL2: begin
        mul_a = t_q;
        mul_b = MULB_W'({1'b0, coef_i.damp});
      end
      ST_C_UPD: mem_we = 1'b1;
      ST_A_RD: begin
        mem_re = 1'b1;
        rline  = 3'd4;
      end
      ST_A_MUL1: begin
        mul_a = rdm;
        mul_b = MULB_W'(coef_i.ap_a);
      end
      ST_A_Z1: begin
        mem_we    = 1'b1;
        wline     = 3'd4;
        mem_wdata = zn + sum_q;
        mem_re    = 1'b1;
        rline     = 3'd5;
      end
      ST_A_MUL2: begin
        mul_a = z_q;
        mul_b = MULB_W'(coef_i.ap_a);
      end
      ST_A_MUL3: begin
        mul_a = y2_q;
        mul_b = MULB_W'(coef_i.ap_b);
      end
      ST_A_Z2: begin
        mem_we    = 1'b1;
        wline     = 3'd5;
        mem_wdata = zn + t_q;
      end
      ST_A_MUL4: begin
        mul_a = z_q;
        mul_b = MULB_W'(coef_i.ap_b);
      end
      ST_MIX_MUL: begin
        mul_a = t_q;
        mul_b = MULB_W'({1'b0, coef_i.mix});
      end
      default: ;
    endcase
  end

  // delay store; entries of a line read as zero until its first lap completes
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      full_q  <= '0;
      damp_q  <= '0;
      cf_q    <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (mem_re) begin
        ok_q <= full_q[rline];
      end
      if (mem_we && pos_q[wline] == '0) begin
        full_q[wline] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl_i.start) begin
            v_q <= sample_i;
            for (int l = 0; l < LINES; l++) begin
              pos_q[l] <= (pos_q[l] == LINE_LEN[bank_i][l] - 1'b1) ? '0 : pos_q[l] + 1'b1;
            end
            state_q <= ST_CF_MUL;
          end
        end
        ST_CF_MUL: state_q <= ST_CF_ADD;
        ST_CF_ADD: begin
          cf_q    <= cf_q + sample_t'(prod_q[55:24]);
          state_q <= ST_X;
        end
        ST_X: begin
          x_q     <= hp_in >>> 2;
          sum_q   <= '0;
          idx_q   <= '0;
          state_q <= ST_C_RD;
        end
        ST_C_RD:  state_q <= ST_C_MUL;
        ST_C_MUL: state_q <= ST_C_SUB;
        ST_C_SUB: begin
          t_q     <= x_q + zn - damp_q[idx_q];
          state_q <= ST_C_MUL2;
        end
        ST_C_MUL2: state_q <= ST_C_UPD;
        ST_C_UPD: begin
          damp_q[idx_q] <= nd;
          sum_q         <= sum_q + nd;
          idx_q         <= idx_q + 1'b1;
          state_q       <= (idx_q == 2'd3) ? ST_A_RD : ST_C_RD;
        end
        ST_A_RD: state_q <= ST_A_MUL1;
        ST_A_MUL1: begin
          y1_q    <= rdm;
          state_q <= ST_A_Z1;
        end
        ST_A_Z1: begin
          z_q     <= zn + sum_q;
          state_q <= ST_A_MUL2;
        end
        ST_A_MUL2: begin
          y2_q    <= rdm;
          state_q <= ST_A_MUL3;
        end
        ST_A_MUL3: begin
          t_q     <= y1_q - zn;
          state_q <= ST_A_Z2;
        end
        ST_A_Z2: begin
          z_q     <= zn + t_q;
          state_q <= ST_A_MUL4;
        end
        ST_A_MUL4: state_q <= ST_A_OUT;
        ST_A_OUT: begin
          t_q     <= y2_q - zn;
          state_q <= ST_MIX_MUL;
        end
        ST_MIX_MUL: state_q <= ST_MIX_OUT;
        ST_MIX_OUT: begin
          res_q   <= zn;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (ctrl_i.take) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign stat_o.done   = (state_q == ST_DONE);
  assign stat_o.result = res_q;

endmodule

>>> hdl/stereo_comb_allpass_reverb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Cross-fed stereo reverb: two channel lanes, outputs merged with the dry input.
// ----------------------------------------------------------------------------
// With reverb active, a lane sequencer in each lane shares one multiplier and
//   the read and write ports of its store; no new word is taken until merge.
// With mix at zero a word passes straight into the output register.
// Reset clears control state, delay line positions, comb state and highpass
//   state; a line's entries read as zero until its first lap ends; no clear pass.
module stereo_comb_allpass_reverb (
  input  logic       clk_i,
  input  logic       rst_ni,
  scar_in_if.sink    in_i,
  scar_out_if.source out_o,
  scar_cfg_if.sink   cfg_i
);
  import scar_pkg::*;

  coef_t      coef_q;
  logic       busy_q;
  logic       out_valid_q;
  sample_t    left_q, right_q, left_out_q, right_out_q;
  lane_ctrl_t ctrl;
  lane_stat_t stat_l, stat_r;
  logic       in_fire, out_free, merge;

  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = !busy_q && out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign merge       = busy_q && stat_l.done && stat_r.done && out_free;

  assign ctrl.start = in_fire && (coef_q.mix != '0);
  assign ctrl.take  = merge;

  // left channel drives the right output's reverb and vice versa
  scar_lane u_lane_l (
    .clk_i, .rst_ni, .bank_i(1'b0), .coef_i(coef_q),
    .sample_i(in_i.left_in), .ctrl_i(ctrl), .stat_o(stat_l)
  );

  scar_lane u_lane_r (
    .clk_i, .rst_ni, .bank_i(1'b1), .coef_i(coef_q),
    .sample_i(in_i.right_in), .ctrl_i(ctrl), .stat_o(stat_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.comb[0] <= RST_COMB_A;
      coef_q.comb[1] <= RST_COMB_B;
      coef_q.comb[2] <= RST_COMB_C;
      coef_q.comb[3] <= RST_COMB_D;
      coef_q.ap_a    <= RST_AP_A;
      coef_q.ap_b    <= RST_AP_B;
      coef_q.damp    <= RST_DAMP;
      coef_q.mix     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_COMB_A:    coef_q.comb[0] <= cfg_i.data[GAIN_W-1:0];
        REG_COMB_B:    coef_q.comb[1] <= cfg_i.data[GAIN_W-1:0];
        REG_COMB_C:    coef_q.comb[2] <= cfg_i.data[GAIN_W-1:0];
        REG_COMB_D:    coef_q.comb[3] <= cfg_i.data[GAIN_W-1:0];
        REG_ALLPASS_A: coef_q.ap_a    <= cfg_i.data[GAIN_W-1:0];
        REG_ALLPASS_B: coef_q.ap_b    <= cfg_i.data[GAIN_W-1:0];
        REG_DAMPING:   coef_q.damp    <= cfg_i.data[DAMP_W-1:0];
        REG_MIX:       coef_q.mix     <= cfg_i.data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        left_q  <= in_i.left_in;
        right_q <= in_i.right_in;
        if (coef_q.mix == '0) begin
          left_out_q  <= in_i.left_in;
          right_out_q <= in_i.right_in;
          out_valid_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end
      if (merge) begin
        left_out_q  <= left_q + stat_r.result;
        right_out_q <= right_q + stat_l.result;
        out_valid_q <= 1'b1;
        busy_q      <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = left_out_q;
  assign out_o.right_out = right_out_q;

endmodule
